### hdl/ibfr_pkg.sv
// Shared types and constants for the iBus frame receiver.
package ibfr_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    localparam logic [2:0] CFG_GAP_TICKS      = 3'd0;
    localparam logic [2:0] CFG_FAILSAFE_TICKS = 3'd1;
    localparam logic [2:0] CFG_INVALID_CODE   = 3'd2;
    localparam logic [2:0] CFG_TIMEOUT_CODE   = 3'd3;

    localparam logic [3:0]  GAP_TICKS_RST      = 4'd3;
    localparam logic [7:0]  FAILSAFE_TICKS_RST = 8'd32;
    localparam logic [15:0] INVALID_CODE_RST   = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_CODE_RST   = 16'hFFFE;

    localparam logic [7:0]  SYNC_BYTE = 8'h20;
    localparam logic [15:0] SUM_INIT  = 16'hFFFF;
    localparam logic [4:0]  GAP_MAX   = 5'd31;
    localparam logic [8:0]  FS_MAX    = 9'd511;

    typedef struct packed {
        logic       is_byte;
        logic       is_tick;
        logic       is_read;
        logic [7:0] rx_byte;
        logic [3:0] channel_index;
        logic       index_bad;
    } op_t;

endpackage

### hdl/ibfr_fifo.sv
// Small register queue between the decode front and the execution back.
module ibfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

### hdl/ibfr_front.sv
// Input decode: classifies each item into an operation for the queue.
module ibfr_front import ibfr_pkg::*; #(
    parameter int NUM_CHANNELS = 10
) (
    input  logic [1:0] s_cmd,
    input  logic [7:0] s_rx_byte,
    input  logic [3:0] s_channel_index,
    output op_t        op
);

    localparam logic [4:0] NUM_CH = 5'(NUM_CHANNELS);

    always_comb begin
        op               = '0;
        op.rx_byte       = s_rx_byte;
        op.channel_index = s_channel_index;
        op.index_bad     = ({1'b0, s_channel_index} >= NUM_CH);
        case (cmd_t'(s_cmd))
            CMD_BYTE: op.is_byte = 1'b1;
            CMD_TICK: op.is_tick = 1'b1;
            CMD_READ: op.is_read = 1'b1;
            default:  op.is_byte = 1'b0;
        endcase
    end

endmodule

### hdl/ibfr_back.sv
// Execution: frame assembly, checksum, timers, channel store, result register.
module ibfr_back import ibfr_pkg::*; #(
    parameter int NUM_CHANNELS = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        op_valid,
    output logic        op_ready,
    input  op_t         op,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_value,
    output logic        m_frame_good,
    output logic        m_frame_bad,
    output logic        m_failsafe_active,
    output logic [5:0]  m_headroom
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [5:0] FRAME_LEN = 6'(2 * NUM_CHANNELS + 12);
    localparam logic [5:0] CHAN_FIRST = 6'd2;
    localparam logic [5:0] CHAN_END = 6'(2 * NUM_CHANNELS + 2);
    localparam logic [5:0] CK_LO_POS = 6'(2 * NUM_CHANNELS + 10);
    localparam logic [5:0] CK_HI_POS = 6'(2 * NUM_CHANNELS + 11);

    logic [3:0]  gap_ticks_reg;
    logic [7:0]  failsafe_ticks_reg;
    logic [15:0] invalid_code_reg;
    logic [15:0] timeout_code_reg;

    logic [5:0]  pos_reg, pos_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  ck_lo_reg, ck_lo_next;
    logic [4:0]  gap_reg, gap_next;
    logic [8:0]  fs_reg, fs_next;
    logic [15:0] staged_reg [NUM_CHANNELS];
    logic [15:0] committed_reg [NUM_CHANNELS];
    logic [15:0] committed_next [NUM_CHANNELS];

    logic        m_valid_reg;
    logic [15:0] read_value_reg, read_value_next;
    logic        good_reg, good_next;
    logic        bad_reg, bad_next;
    logic        fs_flag_reg, fs_flag_next;
    logic [5:0]  headroom_reg;

    logic          pop;
    logic [5:0]    idx_rel;
    logic [CH_W-1:0] stage_ch;
    logic          stage_we, stage_hi;
    logic [4:0]    gap_inc;
    logic [8:0]    fs_inc;

    assign op_ready = !m_valid_reg || m_ready;
    assign pop      = op_valid && op_ready;
    assign idx_rel  = pos_reg - CHAN_FIRST;
    assign stage_ch = idx_rel[CH_W:1];
    assign stage_hi = idx_rel[0];
    assign gap_inc  = (gap_reg == GAP_MAX) ? gap_reg : gap_reg + 5'd1;
    assign fs_inc   = (fs_reg == FS_MAX) ? fs_reg : fs_reg + 9'd1;

    always_comb begin
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        ck_lo_next      = ck_lo_reg;
        gap_next        = gap_reg;
        fs_next         = fs_reg;
        committed_next  = committed_reg;
        stage_we        = 1'b0;
        read_value_next = 16'd0;
        good_next       = 1'b0;
        bad_next        = 1'b0;
        fs_flag_next    = 1'b0;
        if (op.is_byte) begin
            gap_next = 5'd0;
            if (pos_reg == 6'd0 && op.rx_byte != SYNC_BYTE) begin
                pos_next = pos_reg;
            end else if (pos_reg >= FRAME_LEN) begin
                pos_next = 6'd0;
                sum_next = SUM_INIT;
            end else begin
                pos_next = pos_reg + 6'd1;
                if (pos_reg < CK_LO_POS) begin
                    sum_next = sum_reg - {8'd0, op.rx_byte};
                end
                if (pos_reg >= CHAN_FIRST && pos_reg < CHAN_END) begin
                    stage_we = 1'b1;
                end else if (pos_reg == CK_LO_POS) begin
                    ck_lo_next = op.rx_byte;
                end else if (pos_reg == CK_HI_POS) begin
                    if ({op.rx_byte, ck_lo_reg} == sum_reg) begin
                        committed_next = staged_reg;
                        fs_next        = 9'd0;
                        good_next      = 1'b1;
                    end else begin
                        bad_next = 1'b1;
                    end
                    pos_next = 6'd0;
                    sum_next = SUM_INIT;
                end
            end
        end else if (op.is_tick) begin
            gap_next = gap_inc;
            if (gap_inc > {1'b0, gap_ticks_reg}) begin
                pos_next = 6'd0;
                sum_next = SUM_INIT;
            end
            fs_next = fs_inc;
            if (fs_inc > {1'b0, failsafe_ticks_reg}) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    committed_next[i] = timeout_code_reg;
                end
                fs_flag_next = 1'b1;
            end
        end else if (op.is_read) begin
            if (op.index_bad) begin
                read_value_next = invalid_code_reg;
            end else begin
                read_value_next = committed_reg[op.channel_index[CH_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_ticks_reg      <= GAP_TICKS_RST;
            failsafe_ticks_reg <= FAILSAFE_TICKS_RST;
            invalid_code_reg   <= INVALID_CODE_RST;
            timeout_code_reg   <= TIMEOUT_CODE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_GAP_TICKS:      gap_ticks_reg      <= cfg_data[3:0];
                CFG_FAILSAFE_TICKS: failsafe_ticks_reg <= cfg_data[7:0];
                CFG_INVALID_CODE:   invalid_code_reg   <= cfg_data;
                CFG_TIMEOUT_CODE:   timeout_code_reg   <= cfg_data;
                default:            gap_ticks_reg      <= gap_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= 6'd0;
            sum_reg     <= SUM_INIT;
            ck_lo_reg   <= 8'd0;
            gap_reg     <= 5'd0;
            fs_reg      <= 9'd0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                committed_reg[i] <= INVALID_CODE_RST;
            end
        end else begin
            if (pop) begin
                pos_reg       <= pos_next;
                sum_reg       <= sum_next;
                ck_lo_reg     <= ck_lo_next;
                gap_reg       <= gap_next;
                fs_reg        <= fs_next;
                committed_reg <= committed_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            read_value_reg <= read_value_next;
            good_reg       <= good_next;
            bad_reg        <= bad_next;
            fs_flag_reg    <= fs_flag_next;
            headroom_reg   <= FRAME_LEN - pos_next;
        end
        if (pop && stage_we) begin
            if (stage_hi) begin
                staged_reg[stage_ch][15:8] <= op.rx_byte;
            end else begin
                staged_reg[stage_ch] <= {8'd0, op.rx_byte};
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_read_value      = read_value_reg;
    assign m_frame_good      = good_reg;
    assign m_frame_bad       = bad_reg;
    assign m_failsafe_active = fs_flag_reg;
    assign m_headroom        = headroom_reg;

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot0({good_reg, bad_reg, fs_flag_reg}))
        else $error("more than one result flag set");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < FRAME_LEN)
        else $error("byte position past frame end");

    a_headroom_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (headroom_reg == FRAME_LEN - pos_reg))
        else $error("headroom does not match byte position");

    a_good_clears_fs: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && good_next) |=> (fs_reg == 9'd0 && pos_reg == 6'd0))
        else $error("good frame did not clear failsafe timer and position");

endmodule

### hdl/ibus_frame_receiver.sv
// Top level of the iBus frame receiver: decode front, queue, execution back.
// Each item is held in the queue, then its result is registered in the back.
// Throughput: one item per cycle sustained while m_ready holds high; the
// execution stage updates all frame, timer and channel state for each item.
// Reset: aresetn (synchronous, active low) restores register defaults, empties
// the queue and sets every committed channel to 0xFFFF; no clearing pass.
module ibus_frame_receiver import ibfr_pkg::*; #(
    parameter int NUM_CHANNELS = 10,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_rx_byte,
    input  logic [3:0]  s_channel_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_value,
    output logic        m_frame_good,
    output logic        m_frame_bad,
    output logic        m_failsafe_active,
    output logic [5:0]  m_headroom
);

    op_t  front_op;
    op_t  back_op;
    logic q_valid;
    logic q_ready;
    logic [$bits(op_t)-1:0] q_data;

    ibfr_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
        .s_cmd           (s_cmd),
        .s_rx_byte       (s_rx_byte),
        .s_channel_index (s_channel_index),
        .op              (front_op)
    );

    ibfr_fifo #(.WIDTH($bits(op_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (front_op),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    assign back_op = op_t'(q_data);

    ibfr_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .op_valid          (q_valid),
        .op_ready          (q_ready),
        .op                (back_op),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_value      (m_read_value),
        .m_frame_good      (m_frame_good),
        .m_frame_bad       (m_frame_bad),
        .m_failsafe_active (m_failsafe_active),
        .m_headroom        (m_headroom)
    );

endmodule
